>>> rtl/cci_pkg.sv
// Shared types and constants for the cubic curve interpolator.
// Fixed-point widths, mode codes and rounding constants; no dependencies.
package cci_pkg;

	typedef enum logic [1:0] {
		MODE_LERP    = 2'd0,
		MODE_BEZIER  = 2'd1,
		MODE_HERMITE = 2'd2
	} mode_t;

	localparam int COORD_W = 32;
	localparam int T_W     = 17;
	localparam int SQ_W    = 33;
	localparam int CUBE_W  = 49;
	localparam int WX_W    = 52;
	localparam int W_W     = 50;
	localparam int LO_W    = 25;
	localparam int PLO_W   = LO_W + 1 + COORD_W;
	localparam int PHI_W   = W_W - LO_W + COORD_W;
	localparam int PROD_W  = 84;
	localparam int PAIR_W  = 85;
	localparam int SUM_W   = 86;
	localparam int FRAC_W  = 48;
	localparam int V_W     = SUM_W - FRAC_W;

	localparam logic [T_W-1:0] ONE_Q16 = 17'h10000;
	localparam logic signed [WX_W-1:0] ONE_Q48 = 52'sh1_0000_0000_0000;
	localparam logic signed [SUM_W-1:0] HALF_LSB = 86'sh8000_0000_0000;
	localparam logic [COORD_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
	localparam logic [COORD_W-1:0] VAL_MIN = 32'h8000_0000;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [W_W-1:0] weight_t;

endpackage

>>> rtl/cubic_curve_interpolator.sv
// Cubic curve interpolator top level: seven-stage pipeline from t powers to rounded result.
// Depends on cci_pkg for widths, mode codes and rounding constants.
//
// Evaluates one axis of a linear, cubic Bezier or cubic Hermite curve at t (Q1.16, clamped
// to one) from four Q16.16 control values and returns a rounded, saturated Q16.16 value
// with a saturation flag in m_tuser. A new word is taken every cycle while s_tready is high;
// each word's result passes in order through the seven register stages (t squares, t cubes,
// weights, split partial products, product merge, pair sums, final sum with rounding) to
// m_tdata. Each stage loads whenever it is empty or the stage after it moves, so bubbles
// close up under output stalls and s_tready stays high while any stage is empty. Mode code 3
// yields zero, not saturated.
module cubic_curve_interpolator (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// t_frac[16:0], coord_a[48:17], coord_b[80:49], coord_c[112:81], coord_d[144:113]
	input  logic [151:0] s_tdata,
	// mode[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// curve_value[31:0]
	output logic [31:0]  m_tdata,
	// saturated[0]
	output logic         m_tuser
);
	import cci_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	mode_t mode_s1, mode_s2, mode_s3;
	logic [T_W-1:0] t_s1, u_s1, t_s2, u_s2;
	logic [SQ_W-1:0] t2_s1, u2_s1, t2_s2;
	logic [CUBE_W-1:0] t3_s2, u3_s2, tu2_s2, t2u_s2;
	coord_t coord_s1 [4];
	coord_t coord_s2 [4];
	coord_t coord_s3 [4];
	weight_t w_s3 [4];
	logic signed [PLO_W-1:0] plo_s4 [4];
	logic signed [PHI_W-1:0] phi_s4 [4];
	logic signed [PROD_W-1:0] prod_s5 [4];
	logic signed [PAIR_W-1:0] pair_s6 [2];
	logic [COORD_W-1:0] val_s7;
	logic sat_s7;

	logic [T_W-1:0] t_c, u_c;
	logic signed [WX_W-1:0] wx_c [4];
	logic signed [WX_W-1:0] t3x, u3x, tu2x, t2ux, t2s, t1x, ux;
	logic signed [SUM_W-1:0] total_c;
	logic signed [V_W-1:0] v_c;
	logic signed [WX_W-1:0] wsum, whend;

	assign en7 = !v_s7 || m_tready;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_tready = en1;

	assign m_tvalid = v_s7;
	assign m_tdata  = val_s7;
	assign m_tuser  = sat_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	assign t_c = (s_tdata[T_W-1:0] > ONE_Q16) ? ONE_Q16 : s_tdata[T_W-1:0];
	assign u_c = ONE_Q16 - t_c;

	always_ff @(posedge clk) begin
		if (en1) begin
			mode_s1 <= mode_t'(s_tuser);
			t_s1    <= t_c;
			u_s1    <= u_c;
			t2_s1   <= SQ_W'(t_c * t_c);
			u2_s1   <= SQ_W'(u_c * u_c);
			for (int i = 0; i < 4; i++) begin
				coord_s1[i] <= s_tdata[T_W + COORD_W*i +: COORD_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			mode_s2 <= mode_s1;
			t_s2    <= t_s1;
			u_s2    <= u_s1;
			t2_s2   <= t2_s1;
			t3_s2   <= CUBE_W'(t2_s1 * t_s1);
			u3_s2   <= CUBE_W'(u2_s1 * u_s1);
			tu2_s2  <= CUBE_W'(u2_s1 * t_s1);
			t2u_s2  <= CUBE_W'(t2_s1 * u_s1);
			coord_s2 <= coord_s1;
		end
	end

	assign t3x  = $signed({3'b000, t3_s2});
	assign u3x  = $signed({3'b000, u3_s2});
	assign tu2x = $signed({3'b000, tu2_s2});
	assign t2ux = $signed({3'b000, t2u_s2});
	assign t2s  = $signed({3'b000, t2_s2, 16'h0000});
	assign t1x  = $signed({3'b000, t_s2, 32'h0000_0000});
	assign ux   = $signed({3'b000, u_s2, 32'h0000_0000});

	always_comb begin
		case (mode_s2)
			MODE_LERP: begin
				wx_c[0] = ux;
				wx_c[1] = t1x;
				wx_c[2] = '0;
				wx_c[3] = '0;
			end
			MODE_BEZIER: begin
				wx_c[0] = u3x;
				wx_c[1] = tu2x + (tu2x <<< 1);
				wx_c[2] = t2ux + (t2ux <<< 1);
				wx_c[3] = t3x;
			end
			MODE_HERMITE: begin
				wx_c[0] = (t3x <<< 1) - (t2s + (t2s <<< 1)) + ONE_Q48;
				wx_c[1] = t3x - (t2s <<< 1) + t1x;
				wx_c[2] = t3x - t2s;
				wx_c[3] = (t2s + (t2s <<< 1)) - (t3x <<< 1);
			end
			default: begin
				wx_c[0] = '0;
				wx_c[1] = '0;
				wx_c[2] = '0;
				wx_c[3] = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			mode_s3  <= mode_s2;
			coord_s3 <= coord_s2;
			for (int i = 0; i < 4; i++) begin
				w_s3[i] <= wx_c[i][W_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			for (int i = 0; i < 4; i++) begin
				plo_s4[i] <= $signed({1'b0, w_s3[i][LO_W-1:0]}) * coord_s3[i];
				phi_s4[i] <= $signed(w_s3[i][W_W-1:LO_W]) * coord_s3[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			for (int i = 0; i < 4; i++) begin
				prod_s5[i] <= (PROD_W'(phi_s4[i]) <<< LO_W) + PROD_W'(plo_s4[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			pair_s6[0] <= PAIR_W'(prod_s5[0]) + PAIR_W'(prod_s5[1]);
			pair_s6[1] <= PAIR_W'(prod_s5[2]) + PAIR_W'(prod_s5[3]);
		end
	end

	assign total_c = SUM_W'(pair_s6[0]) + SUM_W'(pair_s6[1]) + HALF_LSB;
	assign v_c     = total_c[SUM_W-1:FRAC_W];

	always_ff @(posedge clk) begin
		if (en7) begin
			if (v_c > V_W'(signed'(VAL_MAX))) begin
				val_s7 <= VAL_MAX;
				sat_s7 <= 1'b1;
			end else if (v_c < V_W'(signed'(VAL_MIN))) begin
				val_s7 <= VAL_MIN;
				sat_s7 <= 1'b1;
			end else begin
				val_s7 <= v_c[COORD_W-1:0];
				sat_s7 <= 1'b0;
			end
		end
	end

	assign wsum  = WX_W'(w_s3[0]) + WX_W'(w_s3[1]) + WX_W'(w_s3[2]) + WX_W'(w_s3[3]);
	assign whend = WX_W'(w_s3[0]) + WX_W'(w_s3[3]);

	a_partition: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && (mode_s3 == MODE_LERP || mode_s3 == MODE_BEZIER)) |-> (wsum == ONE_Q48))
		else $error("weights of lerp or Bezier do not sum to one");

	a_hermite_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && mode_s3 == MODE_HERMITE) |-> (whend == ONE_Q48))
		else $error("Hermite point weights do not sum to one");

	a_bad_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && en4 && mode_s3 != MODE_LERP && mode_s3 != MODE_BEZIER
			&& mode_s3 != MODE_HERMITE) |=> (plo_s4[0] == '0 && phi_s4[0] == '0
			&& plo_s4[3] == '0 && phi_s4[3] == '0))
		else $error("undefined mode produced nonzero products");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == VAL_MAX || m_tdata == VAL_MIN))
		else $error("saturated word does not hold a range limit");

endmodule
